@@ hdl/csl_pkg.sv @@
package csl_pkg;

   // Default widths of the position counter and the length counter
   localparam int POSITION_BITS_DEF = 32;
   localparam int LENGTH_BITS_DEF   = 16;

   // Widths of the result fields
   localparam int KIND_W   = 6;
   localparam int OFFSET_W = 32;
   localparam int TLEN_W   = 16;

   // Bytes kept for keyword matching, and the number of keywords
   localparam int PREFIX_N = 6;
   localparam int KW_N     = 13;

   // Token kinds
   localparam logic [KIND_W-1:0] K_IDENT   = 6'd0;
   localparam logic [KIND_W-1:0] K_INT     = 6'd1;
   localparam logic [KIND_W-1:0] K_CHAR    = 6'd2;
   localparam logic [KIND_W-1:0] K_STRING  = 6'd3;
   localparam logic [KIND_W-1:0] K_KW0     = 6'd4;
   localparam logic [KIND_W-1:0] K_PLUS    = 6'd17;
   localparam logic [KIND_W-1:0] K_MINU    = 6'd18;
   localparam logic [KIND_W-1:0] K_MULT    = 6'd19;
   localparam logic [KIND_W-1:0] K_DIV     = 6'd20;
   localparam logic [KIND_W-1:0] K_LSS     = 6'd21;
   localparam logic [KIND_W-1:0] K_LEQ     = 6'd22;
   localparam logic [KIND_W-1:0] K_GRE     = 6'd23;
   localparam logic [KIND_W-1:0] K_GEQ     = 6'd24;
   localparam logic [KIND_W-1:0] K_EQL     = 6'd25;
   localparam logic [KIND_W-1:0] K_NEQ     = 6'd26;
   localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd27;
   localparam logic [KIND_W-1:0] K_SEMI    = 6'd28;
   localparam logic [KIND_W-1:0] K_COMMA   = 6'd29;
   localparam logic [KIND_W-1:0] K_LPAR    = 6'd30;
   localparam logic [KIND_W-1:0] K_RPAR    = 6'd31;
   localparam logic [KIND_W-1:0] K_LBRK    = 6'd32;
   localparam logic [KIND_W-1:0] K_RBRK    = 6'd33;
   localparam logic [KIND_W-1:0] K_LBRC    = 6'd34;
   localparam logic [KIND_W-1:0] K_RBRC    = 6'd35;
   localparam logic [KIND_W-1:0] K_FINISH  = 6'd36;
   localparam logic [KIND_W-1:0] K_ILLEGAL = 6'd37;

   // Request function codes
   localparam logic FN_BYTE = 1'b0;
   localparam logic FN_END  = 1'b1;

   // Scanner modes
   typedef enum logic [3:0] {
      M_IDLE   = 4'd0,
      M_NUM    = 4'd1,
      M_IDENT  = 4'd2,
      M_LT     = 4'd3,
      M_GT     = 4'd4,
      M_EQ     = 4'd5,
      M_BANG   = 4'd6,
      M_CHARWS = 4'd7,
      M_DROP   = 4'd8,
      M_STRING = 4'd9
   } mode_type;

   typedef logic [PREFIX_N-1:0][7:0] prefix_type;

   // One result token
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [OFFSET_W-1:0] start;
      logic [TLEN_W-1:0]   length;
      logic                last;
   } tok_type;

   // Tokens handed from the scanner to the output queue in one cycle
   typedef struct packed {
      logic [1:0] n;
      tok_type    t0;
      tok_type    t1;
   } push_type;

   // Keyword text, byte 0 in the low byte, zero padded
   localparam logic [8*PREFIX_N-1:0] KW_TEXT [KW_N] = '{
      48'h007473_6e6f63,  // const
      48'h000000_746e69,  // int
      48'h000072_616863,  // char
      48'h000064_696f76,  // void
      48'h00006e_69616d,  // main
      48'h000000_006669,  // if
      48'h000065_736c65,  // else
      48'h000000_006f64,  // do
      48'h00656c_696877,  // while
      48'h000000_726f66,  // for
      48'h00666e_616373,  // scanf
      48'h66746e_697270,  // printf
      48'h6e7275_746572   // return
   };
   localparam logic [2:0] KW_LEN [KW_N] = '{
      3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
   };

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || b == "_";
   endfunction

   // Bytes allowed inside a string body
   function automatic logic is_str_body(input logic [7:0] b);
      return b == 8'd32 || b == 8'd33 || (b >= 8'd35 && b <= 8'd126);
   endfunction

   // Bytes accepted as a char literal
   function automatic logic is_char_lit(input logic [7:0] b);
      return is_word(b) || b == "+" || b == "-" || b == "*" || b == "/";
   endfunction

   // Kind of a byte that forms a token by itself at a token start
   function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
      logic [KIND_W-1:0] k;
      unique case (b)
         "+":     k = K_PLUS;
         "-":     k = K_MINU;
         "*":     k = K_MULT;
         "/":     k = K_DIV;
         ";":     k = K_SEMI;
         ",":     k = K_COMMA;
         "(":     k = K_LPAR;
         ")":     k = K_RPAR;
         "[":     k = K_LBRK;
         "]":     k = K_RBRK;
         "{":     k = K_LBRC;
         "}":     k = K_RBRC;
         default: k = K_ILLEGAL;
      endcase
      return k;
   endfunction

   // True when a byte at a token start emits a one-byte token at once
   function automatic logic starts_single(input logic [7:0] b);
      return !is_space(b) && !is_digit(b) && !is_alpha(b) && b != "_" &&
             b != "<" && b != ">" && b != "=" && b != "!" &&
             b != "'" && b != "\"";
   endfunction

   // Keyword lookup; plen is meaningful only while ovf is clear
   function automatic logic [KIND_W-1:0] kw_kind(input prefix_type p,
                                                  input logic [2:0] plen,
                                                  input logic       ovf);
      logic [KIND_W-1:0] k;
      k = K_IDENT;
      if (!ovf) begin
         for (int i = 0; i < KW_N; i++) begin
            if (p == KW_TEXT[i] && plen == KW_LEN[i]) begin
               k = K_KW0 + KIND_W'(i);
            end
         end
      end
      return k;
   endfunction

endpackage

@@ hdl/c_subset_lexer.sv @@
// Streaming lexer for a small C subset.
// Request channel: req_valid/req_stall with req_func (0 = source byte,
// 1 = end of input) and req_char_byte. Response channel: rsp_valid/rsp_stall
// with one token per transfer: rsp_token_kind, rsp_start_offset,
// rsp_token_length, and rsp_last marking the final token caused by a request.
// A request may cause zero, one or two tokens.
// A request is captured in the input register at its accept edge and scanned
// once the token queue has room; its tokens are written into the queue and
// offered from there on rsp_valid. Throughput: one request per cycle while
// the queue has room; the response port moves one token per cycle while
// rsp_stall is low, so requests that yield two tokens take two transfers.
// A four-entry token queue sits between the scanner and the response port;
// req_stall rises when the input register is full and the queue has fewer
// than two free entries, so a stalled receiver backs up into the request side
// without losing tokens.
// Reset clears the scanner to idle, positions and lengths to zero, and
// empties the queue; the block accepts requests once reset is released.
module c_subset_lexer #(
   parameter int POSITION_BITS = csl_pkg::POSITION_BITS_DEF,
   parameter int LENGTH_BITS   = csl_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [31:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last
);

   csl_pkg::push_type push;
   csl_pkg::tok_type  head;
   logic              room;

   // Scanner: input register, state and token step
   csl_scan #(
      .POSITION_BITS(POSITION_BITS),
      .LENGTH_BITS  (LENGTH_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_char_byte(req_char_byte),
      .room         (room),
      .push         (push)
   );

   // Token queue toward the response port
   csl_tokq u_tokq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .head     (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_start_offset = head.start;
   assign rsp_token_length = head.length;
   assign rsp_last         = head.last;

endmodule

@@ hdl/csl_scan.sv @@
// Input register, scanner state and the per-byte lexing step
module csl_scan #(
   parameter int POSITION_BITS = csl_pkg::POSITION_BITS_DEF,
   parameter int LENGTH_BITS   = csl_pkg::LENGTH_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [7:0]        req_char_byte,
   input  logic              room,
   output csl_pkg::push_type push
);

   localparam int KW = csl_pkg::KIND_W;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic       in_func_ff;
   logic [7:0] in_byte_ff;

   // Scanner state
   csl_pkg::mode_type          mode_ff, mode_in;
   logic [POSITION_BITS-1:0]   pos_ff, pos_in;
   logic [POSITION_BITS-1:0]   tstart_ff, tstart_in;
   logic [LENGTH_BITS-1:0]     len_ff, len_in;
   csl_pkg::prefix_type        prefix_ff, prefix_in;
   logic                       ovf_ff, ovf_in;

   logic                       fire, accept;
   logic [7:0]                 b;
   logic                       pending, terminated, restart;
   logic [KW-1:0]              close_kind;
   logic [LENGTH_BITS-1:0]     close_len;
   logic [LENGTH_BITS-1:0]     len_grow;

   // Raw tokens of this step
   logic                       e0_v, e1_v;
   logic [KW-1:0]              e0_kind, e1_kind;
   logic [POSITION_BITS-1:0]   e0_start, e1_start;
   logic [LENGTH_BITS-1:0]     e0_len, e1_len;
   csl_pkg::tok_type           tk0, tk1;

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign b         = in_byte_ff;
   assign len_grow  = (len_ff == '1) ? len_ff : len_ff + 1'b1;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_char_byte;
      end
   end

   // Pending token and whether this byte ends it
   always_comb begin
      pending    = 1'b0;
      terminated = 1'b0;
      close_kind = csl_pkg::K_ILLEGAL;
      close_len  = LENGTH_BITS'(1);
      unique case (mode_ff)
         csl_pkg::M_NUM: begin
            pending    = 1'b1;
            terminated = !csl_pkg::is_digit(b);
            close_kind = csl_pkg::K_INT;
            close_len  = len_ff;
         end
         csl_pkg::M_IDENT: begin
            pending    = 1'b1;
            terminated = !csl_pkg::is_word(b);
            close_kind = csl_pkg::kw_kind(prefix_ff, len_ff[2:0], ovf_ff);
            close_len  = len_ff;
         end
         csl_pkg::M_LT: begin
            pending    = 1'b1;
            terminated = b != "=";
            close_kind = csl_pkg::K_LSS;
         end
         csl_pkg::M_GT: begin
            pending    = 1'b1;
            terminated = b != "=";
            close_kind = csl_pkg::K_GRE;
         end
         csl_pkg::M_EQ: begin
            pending    = 1'b1;
            terminated = b != "=";
            close_kind = csl_pkg::K_ASSIGN;
         end
         csl_pkg::M_BANG: begin
            pending    = 1'b1;
            terminated = b != "=";
            close_kind = csl_pkg::K_ILLEGAL;
         end
         default: begin
         end
      endcase
   end

   // A fresh token start is scanned from this byte
   assign restart = (in_func_ff == csl_pkg::FN_BYTE) &&
                    (mode_ff == csl_pkg::M_IDLE || terminated);

   // Next state
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      len_in    = len_ff;
      prefix_in = prefix_ff;
      ovf_in    = ovf_ff;
      if (fire) begin
         if (in_func_ff == csl_pkg::FN_END) begin
            mode_in = csl_pkg::M_IDLE;
         end else begin
            pos_in = pos_ff + 1'b1;
            unique case (mode_ff)
               csl_pkg::M_NUM: begin
                  if (!terminated) len_in = len_grow;
               end
               csl_pkg::M_IDENT: begin
                  if (!terminated) begin
                     if (len_ff < LENGTH_BITS'(csl_pkg::PREFIX_N)) begin
                        prefix_in[len_ff[2:0]] = b;
                     end else begin
                        ovf_in = 1'b1;
                     end
                     len_in = len_grow;
                  end
               end
               csl_pkg::M_LT, csl_pkg::M_GT, csl_pkg::M_EQ, csl_pkg::M_BANG: begin
                  if (!terminated) mode_in = csl_pkg::M_IDLE;
               end
               csl_pkg::M_CHARWS: begin
                  if (!csl_pkg::is_space(b)) mode_in = csl_pkg::M_DROP;
               end
               csl_pkg::M_DROP: begin
                  mode_in = csl_pkg::M_IDLE;
               end
               csl_pkg::M_STRING: begin
                  if (b == "\"") begin
                     mode_in = csl_pkg::M_IDLE;
                  end else if (csl_pkg::is_str_body(b)) begin
                     len_in = len_grow;
                  end else begin
                     mode_in = csl_pkg::M_DROP;
                  end
               end
               default: begin
               end
            endcase
            // Fresh start overrides whatever the pending mode did
            if (restart) begin
               mode_in = csl_pkg::M_IDLE;
               if (!csl_pkg::is_space(b)) tstart_in = pos_ff;
               priority if (csl_pkg::is_space(b)) begin
                  mode_in = csl_pkg::M_IDLE;
               end else if (csl_pkg::is_digit(b)) begin
                  mode_in = csl_pkg::M_NUM;
                  len_in  = LENGTH_BITS'(1);
               end else if (csl_pkg::is_alpha(b) || b == "_") begin
                  mode_in      = csl_pkg::M_IDENT;
                  len_in       = LENGTH_BITS'(1);
                  prefix_in    = '0;
                  prefix_in[0] = b;
                  ovf_in       = 1'b0;
               end else if (b == "<") begin
                  mode_in = csl_pkg::M_LT;
               end else if (b == ">") begin
                  mode_in = csl_pkg::M_GT;
               end else if (b == "=") begin
                  mode_in = csl_pkg::M_EQ;
               end else if (b == "!") begin
                  mode_in = csl_pkg::M_BANG;
               end else if (b == "'") begin
                  mode_in = csl_pkg::M_CHARWS;
               end else if (b == "\"") begin
                  mode_in   = csl_pkg::M_STRING;
                  tstart_in = pos_ff + 1'b1;
                  len_in    = '0;
               end else begin
                  mode_in = csl_pkg::M_IDLE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= csl_pkg::M_IDLE;
         pos_ff    <= '0;
         tstart_ff <= '0;
         len_ff    <= '0;
         prefix_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         tstart_ff <= tstart_in;
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
         ovf_ff    <= ovf_in;
      end
   end

   // Tokens of this step: e0 closes or finishes something, e1 is the tail
   always_comb begin
      e0_v     = 1'b0;
      e0_kind  = csl_pkg::K_ILLEGAL;
      e0_start = pos_ff;
      e0_len   = LENGTH_BITS'(1);
      e1_v     = 1'b0;
      e1_kind  = csl_pkg::K_ILLEGAL;
      e1_start = pos_ff;
      e1_len   = LENGTH_BITS'(1);
      if (in_func_ff == csl_pkg::FN_END) begin
         if (mode_ff == csl_pkg::M_CHARWS || mode_ff == csl_pkg::M_STRING) begin
            e0_v   = 1'b1;
            e0_len = '0;
         end else if (pending) begin
            e0_v     = 1'b1;
            e0_kind  = close_kind;
            e0_start = tstart_ff;
            e0_len   = close_len;
         end
         e1_v    = 1'b1;
         e1_kind = csl_pkg::K_FINISH;
         e1_len  = '0;
      end else begin
         unique case (mode_ff)
            csl_pkg::M_NUM, csl_pkg::M_IDENT: begin
               if (terminated) begin
                  e0_v     = 1'b1;
                  e0_kind  = close_kind;
                  e0_start = tstart_ff;
                  e0_len   = close_len;
               end
            end
            csl_pkg::M_LT, csl_pkg::M_GT, csl_pkg::M_EQ, csl_pkg::M_BANG: begin
               e0_v     = 1'b1;
               e0_start = tstart_ff;
               if (terminated) begin
                  e0_kind = close_kind;
               end else begin
                  e0_len = LENGTH_BITS'(2);
                  unique case (mode_ff)
                     csl_pkg::M_LT: e0_kind = csl_pkg::K_LEQ;
                     csl_pkg::M_GT: e0_kind = csl_pkg::K_GEQ;
                     csl_pkg::M_EQ: e0_kind = csl_pkg::K_EQL;
                     default:       e0_kind = csl_pkg::K_NEQ;
                  endcase
               end
            end
            csl_pkg::M_CHARWS: begin
               if (!csl_pkg::is_space(b)) begin
                  e0_v    = 1'b1;
                  e0_kind = csl_pkg::is_char_lit(b) ? csl_pkg::K_CHAR : csl_pkg::K_ILLEGAL;
               end
            end
            csl_pkg::M_STRING: begin
               if (b == "\"") begin
                  e0_v     = 1'b1;
                  e0_kind  = csl_pkg::K_STRING;
                  e0_start = tstart_ff;
                  e0_len   = len_ff;
               end else if (!csl_pkg::is_str_body(b)) begin
                  e0_v = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (restart && csl_pkg::starts_single(b)) begin
            e1_v    = 1'b1;
            e1_kind = csl_pkg::single_kind(b);
         end
      end
   end

   // Pack into result format: offset wraps at 32 bits, length saturates
   function automatic csl_pkg::tok_type make_tok(input logic [KW-1:0] k,
                                                 input logic [POSITION_BITS-1:0] s,
                                                 input logic [LENGTH_BITS-1:0] l,
                                                 input logic lst);
      csl_pkg::tok_type t;
      logic [63:0]      s_wide;
      logic [31:0]      l_wide;
      s_wide   = 64'(s);
      l_wide   = 32'(l);
      t.kind   = k;
      t.start  = s_wide[csl_pkg::OFFSET_W-1:0];
      t.length = (l_wide > 32'h0000_FFFF) ? '1 : l_wide[csl_pkg::TLEN_W-1:0];
      t.last   = lst;
      return t;
   endfunction

   always_comb begin
      tk0 = make_tok(e0_kind, e0_start, e0_len, !e1_v);
      tk1 = make_tok(e1_kind, e1_start, e1_len, 1'b1);
      push.t0 = e0_v ? tk0 : tk1;
      push.t1 = tk1;
      push.n  = fire ? (2'(e0_v) + 2'(e1_v)) : 2'd0;
   end

   // An end of input always ends with a finish token
   assert property (@(posedge clock) disable iff (reset)
      fire && in_func_ff == csl_pkg::FN_END |->
         push.n != 2'd0 && push.t1.kind == csl_pkg::K_FINISH)
      else $error("end of input did not end in finish");

   // Nothing is pushed unless the queue has room
   assert property (@(posedge clock) disable iff (reset)
      push.n != 2'd0 |-> room)
      else $error("push without queue room");

   // The scanner is idle after an end of input
   assert property (@(posedge clock) disable iff (reset)
      fire && in_func_ff == csl_pkg::FN_END |=> mode_ff == csl_pkg::M_IDLE)
      else $error("scanner not idle after end of input");

endmodule

@@ hdl/csl_tokq.sv @@
// Four-entry token queue: takes up to two tokens a cycle, gives one while rsp_stall is low
module csl_tokq (
   input  logic              clock,
   input  logic              reset,
   input  csl_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output csl_pkg::tok_type  head
);

   csl_pkg::tok_type mem_ff [4];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             pop;
   logic [1:0]       wr_ptr_nx;

   assign rsp_valid = cnt_ff != 3'd0;
   assign room      = cnt_ff <= 3'd2;
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = mem_ff[rd_ptr_ff];
   assign wr_ptr_nx = wr_ptr_ff + 2'd1;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.n;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      cnt_in    = cnt_ff + 3'(push.n) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry writes
   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.t0;
      end
      if (push.n == 2'd2) begin
         mem_ff[wr_ptr_nx] <= push.t1;
      end
   end

   // Occupancy stays within the four entries
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("token queue over capacity");

   // A push never overruns the queue
   assert property (@(posedge clock) disable iff (reset)
      push.n != 2'd0 |-> 4'(cnt_ff) + 4'(push.n) <= 4'd4)
      else $error("token queue overrun");

   // An empty queue with no push stays empty
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 3'd0 && push.n == 2'd0 |=> cnt_ff == 3'd0)
      else $error("token queue count moved without a push");

endmodule

@@ bench/c_subset_lexer_tb.sv @@
module c_subset_lexer_tb;
   import csl_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int PRINT_CAP   = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [7:0]  req_char_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_token_kind;
   logic [31:0] rsp_start_offset;
   logic [15:0] rsp_token_length;
   logic        rsp_last;

   // Idle rates in percent for the request and response sides
   int send_idle;
   int rcv_idle;
   int items_sent;
   int err_count;
   int quiet_cycles;
   int tokens_seen;

   // Scanner state mirrored by the token predictor
   mode_type    scan_st;
   logic [31:0] scan_pos;
   logic [31:0] tok_start;
   logic [15:0] lex_len;
   logic [7:0]  kw_buf [PREFIX_N];
   logic        kw_ovf;

   tok_type step_toks [$];
   tok_type tokens_due [$];
   tok_type want;

   string kw_words [KW_N] = '{"const", "int", "char", "void", "main", "if", "else",
                              "do", "while", "for", "scanf", "printf", "return"};
   string op_words [20] = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "==", "!=",
                            "=", ";", ",", "(", ")", "[", "]", "{", "}", "!"};

   c_subset_lexer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_char_byte    (req_char_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Byte classes
   // ---------------------------------------------------------------
   function automatic logic ws_byte(input logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic digit_byte(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic letter_byte(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic word_byte(input logic [7:0] b);
      return letter_byte(b) || digit_byte(b) || b == "_";
   endfunction

   function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
      case (b)
         "+": return K_PLUS;
         "-": return K_MINU;
         "*": return K_MULT;
         "/": return K_DIV;
         ";": return K_SEMI;
         ",": return K_COMMA;
         "(": return K_LPAR;
         ")": return K_RPAR;
         "[": return K_LBRK;
         "]": return K_RBRK;
         "{": return K_LBRC;
         "}": return K_RBRC;
         default: return K_ILLEGAL;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Token predictor
   // ---------------------------------------------------------------
   function automatic void add_token(input logic [KIND_W-1:0] k, input logic [31:0] s,
                                     input logic [15:0] n);
      tok_type t;
      t.kind   = k;
      t.start  = s;
      t.length = n;
      t.last   = 1'b0;
      step_toks.push_back(t);
   endfunction

   function automatic void bump_len();
      if (lex_len != 16'hFFFF) lex_len = lex_len + 16'd1;
   endfunction

   // Keyword match on the kept prefix
   function automatic logic [KIND_W-1:0] word_kind();
      logic hit;
      if (kw_ovf) return K_IDENT;
      for (int i = 0; i < KW_N; i++) begin
         if (kw_words[i].len() == lex_len) begin
            hit = 1'b1;
            for (int j = 0; j < kw_words[i].len(); j++)
               if (kw_buf[j] != kw_words[i][j]) hit = 1'b0;
            if (hit) return K_KW0 + KIND_W'(i);
         end
      end
      return K_IDENT;
   endfunction

   function automatic void close_token();
      case (scan_st)
         M_NUM:   add_token(K_INT, tok_start, lex_len);
         M_IDENT: add_token(word_kind(), tok_start, lex_len);
         M_LT:    add_token(K_LSS, tok_start, 16'd1);
         M_GT:    add_token(K_GRE, tok_start, 16'd1);
         M_EQ:    add_token(K_ASSIGN, tok_start, 16'd1);
         M_BANG:  add_token(K_ILLEGAL, tok_start, 16'd1);
         default: ;
      endcase
      scan_st = M_IDLE;
   endfunction

   function automatic void start_token(input logic [7:0] b);
      scan_st = M_IDLE;
      if (ws_byte(b)) return;
      tok_start = scan_pos;
      if (digit_byte(b)) begin
         scan_st = M_NUM;
         lex_len = 16'd1;
      end else if (letter_byte(b) || b == "_") begin
         scan_st = M_IDENT;
         lex_len = 16'd1;
         foreach (kw_buf[i]) kw_buf[i] = 8'd0;
         kw_buf[0] = b;
         kw_ovf = 1'b0;
      end else begin
         case (b)
            "<":  scan_st = M_LT;
            ">":  scan_st = M_GT;
            "=":  scan_st = M_EQ;
            "!":  scan_st = M_BANG;
            "'":  scan_st = M_CHARWS;
            "\"": begin
               scan_st   = M_STRING;
               tok_start = scan_pos + 32'd1;
               lex_len   = 16'd0;
            end
            default: add_token(punct_kind(b), scan_pos, 16'd1);
         endcase
      end
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      logic [KIND_W-1:0] k;
      case (scan_st)
         M_NUM: begin
            if (digit_byte(b)) bump_len();
            else begin
               close_token();
               start_token(b);
            end
         end
         M_IDENT: begin
            if (word_byte(b)) begin
               if (lex_len < PREFIX_N) kw_buf[lex_len] = b;
               else kw_ovf = 1'b1;
               bump_len();
            end else begin
               close_token();
               start_token(b);
            end
         end
         M_LT, M_GT, M_EQ, M_BANG: begin
            if (b == "=") begin
               case (scan_st)
                  M_LT:    k = K_LEQ;
                  M_GT:    k = K_GEQ;
                  M_EQ:    k = K_EQL;
                  default: k = K_NEQ;
               endcase
               add_token(k, tok_start, 16'd2);
               scan_st = M_IDLE;
            end else begin
               close_token();
               start_token(b);
            end
         end
         M_CHARWS: begin
            if (!ws_byte(b)) begin
               if (word_byte(b) || b == "+" || b == "-" || b == "*" || b == "/")
                  add_token(K_CHAR, scan_pos, 16'd1);
               else
                  add_token(K_ILLEGAL, scan_pos, 16'd1);
               scan_st = M_DROP;
            end
         end
         M_DROP: scan_st = M_IDLE;
         M_STRING: begin
            if (b == "\"") begin
               add_token(K_STRING, tok_start, lex_len);
               scan_st = M_IDLE;
            end else if (b == 8'd32 || b == 8'd33 || (b >= 8'd35 && b <= 8'd126)) begin
               bump_len();
            end else begin
               add_token(K_ILLEGAL, scan_pos, 16'd1);
               scan_st = M_DROP;
            end
         end
         default: start_token(b);
      endcase
      scan_pos = scan_pos + 32'd1;
   endfunction

   function automatic void take_end();
      if (scan_st == M_CHARWS || scan_st == M_STRING)
         add_token(K_ILLEGAL, scan_pos, 16'd0);
      else
         close_token();
      add_token(K_FINISH, scan_pos, 16'd0);
      scan_st = M_IDLE;
   endfunction

   // Expected tokens of one accepted request; last marks the final one
   function automatic void predict_tokens(input logic fn, input logic [7:0] b);
      tok_type t;
      step_toks.delete();
      if (fn == FN_END) take_end();
      else take_byte(b);
      for (int i = 0; i < step_toks.size(); i++) begin
         t = step_toks[i];
         t.last = (i == step_toks.size() - 1);
         tokens_due.push_back(t);
      end
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   task automatic send_item(input logic fn, input logic [7:0] b);
      while (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= fn;
      req_char_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tokens(fn, b);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(FN_BYTE, s[i]);
   endtask

   function automatic logic [7:0] rand_ws();
      int r;
      r = $urandom_range(5);
      return (r == 5) ? 8'd32 : 8'(9 + r);
   endfunction

   function automatic logic [7:0] rand_word_ch(input bit lead);
      int r;
      r = lead ? $urandom_range(52) : $urandom_range(62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   // One lexeme of random content, mostly well formed, then maybe a blank
   task automatic send_random_lexeme();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 15) begin
         send_text(kw_words[$urandom_range(KW_N - 1)]);
         if ($urandom_range(3) == 0) send_item(FN_BYTE, rand_word_ch(1'b0));
      end else if (pick < 28) begin
         n = $urandom_range(9, 1);
         send_item(FN_BYTE, rand_word_ch(1'b1));
         repeat (n - 1) send_item(FN_BYTE, rand_word_ch(1'b0));
      end else if (pick < 38) begin
         repeat ($urandom_range(5, 1)) send_item(FN_BYTE, 8'("0" + $urandom_range(9)));
      end else if (pick < 60) begin
         send_text(op_words[$urandom_range(19)]);
      end else if (pick < 70) begin
         // char literal: quote, optional blanks, the char, then a dropped byte
         send_item(FN_BYTE, "'");
         repeat ($urandom_range(2)) send_item(FN_BYTE, rand_ws());
         if ($urandom_range(9) < 7) send_item(FN_BYTE, rand_word_ch(1'b0));
         else send_item(FN_BYTE, 8'($urandom_range(255)));
         send_item(FN_BYTE, 8'($urandom_range(255)));
      end else if (pick < 80) begin
         send_item(FN_BYTE, "\"");
         repeat ($urandom_range(6)) begin
            if ($urandom_range(9) != 0) send_item(FN_BYTE, 8'($urandom_range(126, 32)));
            else send_item(FN_BYTE, 8'($urandom_range(255)));
         end
         if ($urandom_range(4) != 0) send_item(FN_BYTE, "\"");
      end else if (pick < 88) begin
         send_item(FN_BYTE, 8'($urandom_range(255)));
      end else if (pick < 92) begin
         send_item(FN_END, 8'($urandom_range(255)));
      end else begin
         send_item(FN_BYTE, rand_ws());
      end
      if ($urandom_range(9) < 6) send_item(FN_BYTE, rand_ws());
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Stray bytes, lone bang, char literal with blanks, empty string,
   // bad byte in a string, operator pairs, end inside literals
   task automatic test_directed();
      send_item(FN_BYTE, 8'h00);
      send_item(FN_BYTE, 8'hFF);
      send_text("!=!x '\tq7\"\"\"a");
      send_item(FN_BYTE, 8'h01);
      send_text("b<>=_9");
      send_item(FN_END, 8'h00);
      send_text("\"ab");
      send_item(FN_END, 8'hFF);
      send_text("'");
      send_item(FN_END, 8'h00);
   endtask

   task automatic test_random_mix(input int tx_pct, input int rx_pct, input int count);
      int stop_at;
      send_idle = tx_pct;
      rcv_idle  = rx_pct;
      stop_at   = items_sent + count;
      while (items_sent < stop_at) send_random_lexeme();
   endtask

   // Long digit run, identifier past the kept prefix and a long string body
   task automatic test_long_lexemes();
      send_idle = 0;
      rcv_idle  = 0;
      send_text(" ");
      repeat (40) send_item(FN_BYTE, 8'("0" + $urandom_range(9)));
      send_item(FN_BYTE, rand_ws());
      send_text("printf_");
      repeat (12) send_item(FN_BYTE, rand_word_ch(1'b0));
      send_item(FN_BYTE, ";");
      send_item(FN_BYTE, "\"");
      repeat (30) send_item(FN_BYTE, 8'($urandom_range(126, 35)));
      send_item(FN_BYTE, "\"");
      send_item(FN_END, 8'h00);
   endtask

   // ---------------------------------------------------------------
   // Response side: check and random stall
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what);
      if (err_count < PRINT_CAP) $display("token %0d: %s", tokens_seen, what);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tokens_due.size() == 0) begin
               report_mismatch("token arrived with none expected");
            end else begin
               want = tokens_due.pop_front();
               if (rsp_token_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d",
                                            rsp_token_kind, want.kind));
               if (rsp_start_offset !== want.start)
                  report_mismatch($sformatf("start %0d, expected %0d",
                                            rsp_start_offset, want.start));
               if (rsp_token_length !== want.length)
                  report_mismatch($sformatf("length %0d, expected %0d",
                                            rsp_token_length, want.length));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
            end
            tokens_seen++;
         end
         rsp_stall <= (rcv_idle != 0) && ($urandom_range(99) < rcv_idle);
      end
   end

   // Watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("c_subset_lexer: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FN_BYTE;
      req_char_byte = 8'd0;
      rsp_stall     = 1'b0;
      send_idle     = 0;
      rcv_idle      = 0;
      items_sent    = 0;
      err_count     = 0;
      quiet_cycles  = 0;
      tokens_seen   = 0;
      scan_st       = M_IDLE;
      scan_pos      = 32'd0;
      tok_start     = 32'd0;
      lex_len       = 16'd0;
      kw_ovf        = 1'b0;
      foreach (kw_buf[i]) kw_buf[i] = 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(28, 53, 260);
      test_random_mix(53, 28, 260);
      test_random_mix(0, 0, 260);
      test_long_lexemes();

      req_valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_count == 0)
         $display("c_subset_lexer: match");
      else
         $display("c_subset_lexer: mismatch");
      $finish;
   end

endmodule
